### rtl/mlit_pkg.sv
package mlit_pkg;

    // table size default and field widths
    localparam int MLIT_ENTRIES = 32;
    localparam int ID_W         = 32;
    localparam int TIME_W       = 32;
    localparam int LIMIT_W      = 16;
    localparam int NUM_LEVELS   = 3;
    localparam int LEVEL_W      = 2;
    localparam int FUNC_W       = 3;
    localparam int CFG_IDX_W    = 2;

    // queue depths
    localparam int CMDQ_DEPTH   = 2;
    localparam int RESQ_DEPTH   = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONFIGURE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FOCUS     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_L0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_L1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_L2 = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DESTROY,
        OP_FOCUS,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] level;
        logic               last;
        logic               overflowed;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [TIME_W-1:0]     last_active;
        logic [NUM_LEVELS-1:0] done;
    } t_slot;

    typedef logic [NUM_LEVELS-1:0][LIMIT_W-1:0] t_limits;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PRE,
        BS_SCAN,
        BS_POST
    } t_bstate;

endpackage

### rtl/mlit_front.sv
module mlit_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mlit_pkg::FUNC_W-1:0] i_func,
    input  logic [mlit_pkg::ID_W-1:0]   i_item_id,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_pop,
    output mlit_pkg::t_cmd              o_cmd
);
    import mlit_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMDQ_DEPTH - 1);

    t_cmd             r_q [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_op              op;
    logic             wr, rd;

    // classify: zero id on add, configure or destroy does nothing, unused codes dropped
    always_comb begin
        case (i_func)
            FUNC_ADD, FUNC_CONFIGURE: op = (i_item_id != '0) ? OP_INSERT : OP_NONE;
            FUNC_DESTROY:             op = (i_item_id != '0) ? OP_DESTROY : OP_NONE;
            FUNC_FOCUS:               op = OP_FOCUS;
            FUNC_TICK:                op = OP_TICK;
            default:                  op = OP_NONE;
        endcase
    end

    assign full        = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full && (op != OP_NONE);
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{op: op, id: i_item_id};
        end
    end

endmodule

### rtl/mlit_outq.sv
module mlit_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mlit_pkg::t_result i_data,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output mlit_pkg::t_result o_data
);
    import mlit_pkg::*;

    localparam int PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RESQ_DEPTH - 1);

    t_result          r_q [RESQ_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr, rd;

    assign o_full = (r_cnt == CNT_W'(RESQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_data = r_q[r_rp];
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

### rtl/mlit_back.sv
module mlit_back #(
    parameter int ENTRIES = mlit_pkg::MLIT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  mlit_pkg::t_cmd    i_cmd,
    input  mlit_pkg::t_limits i_limits,
    input  logic              i_out_full,
    output logic              o_res_push,
    output mlit_pkg::t_result o_res
);
    import mlit_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_bstate             r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [ID_W-1:0]     r_focus, n_focus;
    logic                r_ovf, n_ovf;
    logic                r_hit, n_hit;
    logic                r_free_v, n_free_v;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic                r_pend_v, n_pend_v;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [LEVEL_W-1:0]  r_pend_lvl, n_pend_lvl;

    // slot memory, one read and one write port, registered read
    t_slot               r_mem [ENTRIES];
    t_slot               r_rd;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    t_slot               mem_wd;
    logic [IDX_W-1:0]    rd_addr;

    logic [NUM_LEVELS-1:0] elapsed;
    logic                  sel_v;
    logic [LEVEL_W-1:0]    sel_lvl;
    logic                  go, slot_v, id_hit, foc_hit, last_slot;

    // idle check per level, 33-bit so the sum cannot wrap
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            elapsed[l] = (i_limits[l] != '0) &&
                (({1'b0, r_rd.last_active} + (TIME_W+1)'(i_limits[l])) <= {1'b0, r_now});
        end
    end

    // highest elapsed level is the only candidate
    always_comb begin
        sel_v   = 1'b0;
        sel_lvl = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (elapsed[l]) begin
                sel_v   = 1'b1;
                sel_lvl = LEVEL_W'(l);
            end
        end
    end

    assign go        = !i_out_full;
    assign slot_v    = r_valid[r_idx];
    assign id_hit    = slot_v && (r_rd.id == r_cmd.id);
    assign foc_hit   = slot_v && (r_rd.id == r_focus);
    assign last_slot = (r_idx == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_now      = r_now;
        n_focus    = r_focus;
        n_ovf      = r_ovf;
        n_hit      = r_hit;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_pend_lvl = r_pend_lvl;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        mem_wd     = r_rd;
        rd_addr    = r_idx;
        o_res_push = 1'b0;
        o_res      = '{id: r_pend_id, level: r_pend_lvl, last: 1'b0, overflowed: r_ovf};

        case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = BS_PRE;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free_v  = 1'b0;
                    n_pend_v  = 1'b0;
                    if (i_cmd.op == OP_TICK && r_now != TIME_MAX) begin
                        n_now = r_now + 1'b1;
                    end
                end
            end
            BS_PRE: begin
                rd_addr = '0;
                n_state = BS_SCAN;
            end
            BS_SCAN: begin
                if (go) begin
                    rd_addr = last_slot ? '0 : r_idx + 1'b1;
                    n_idx   = rd_addr;
                    if (last_slot) begin
                        n_state = BS_POST;
                    end
                    if (!slot_v && !r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_idx;
                    end
                    case (r_cmd.op)
                        OP_INSERT: begin
                            if (id_hit) begin
                                n_hit = 1'b1;
                            end
                        end
                        OP_DESTROY: begin
                            if (id_hit) begin
                                n_valid[r_idx] = 1'b0;
                            end
                        end
                        OP_FOCUS: begin
                            if (id_hit) begin
                                n_hit = 1'b1;
                            end
                            if (id_hit || foc_hit) begin
                                mem_we = 1'b1;
                                mem_wd = '{id: r_rd.id, last_active: r_now, done: '0};
                            end
                        end
                        OP_TICK: begin
                            if (foc_hit) begin
                                mem_we             = 1'b1;
                                mem_wd.last_active = r_now;
                            end else if (slot_v && sel_v && !r_rd.done[sel_lvl]) begin
                                mem_we              = 1'b1;
                                mem_wd.done[sel_lvl] = 1'b1;
                                o_res_push          = r_pend_v;
                                n_pend_v            = 1'b1;
                                n_pend_id           = r_rd.id;
                                n_pend_lvl          = sel_lvl;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_POST: begin
                case (r_cmd.op)
                    OP_INSERT, OP_FOCUS: begin
                        if (r_cmd.id != '0 && !r_hit) begin
                            if (r_free_v) begin
                                mem_we              = 1'b1;
                                mem_wa              = r_free_idx;
                                mem_wd              = '{id: r_cmd.id, last_active: r_now,
                                                        done: '0};
                                n_valid[r_free_idx] = 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (r_cmd.op == OP_FOCUS) begin
                    n_focus = r_cmd.id;
                end
                if (r_cmd.op == OP_TICK && r_pend_v) begin
                    if (go) begin
                        o_res_push = 1'b1;
                        o_res.last = 1'b1;
                        n_pend_v   = 1'b0;
                        n_state    = BS_IDLE;
                    end
                end else begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_idx    <= '0;
            r_valid  <= '0;
            r_now    <= '0;
            r_focus  <= '0;
            r_ovf    <= 1'b0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_valid  <= n_valid;
            r_now    <= n_now;
            r_focus  <= n_focus;
            r_ovf    <= n_ovf;
            r_hit    <= n_hit;
            r_free_v <= n_free_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_free_idx <= n_free_idx;
        r_pend_id  <= n_pend_id;
        r_pend_lvl <= n_pend_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("slot scan index beyond table");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_out_full)
        else $error("result pushed into full result queue");

    a_now_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_now >= $past(r_now)))
        else $error("time counter went backwards");

    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cmd.op == OP_TICK))
        else $error("held result outside a tick");

endmodule

### rtl/multi_level_idle_timeout_table_top.sv
// idle-timeout table with three action levels
//
// input channel: push / full with i_func and i_item_id; a beat is taken when
// push is high and full is low. add and configure insert an id, destroy
// removes it, focus moves the focus, tick advances time and scans the table
// result channel: empty / pop; the oldest action sits on o_acted_id,
// o_action_level, o_last_of_tick and o_table_overflowed while empty is low
// config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// picks the level 0, 1 or 2 idle limit, other indexes are ignored
// timing: a front stage decodes beats into a two-entry command queue; the
// back end walks every slot of the table memory for each command, whatever
// its kind, one slot per cycle while the result queue has room.
// the slot walk is what sets the rate; the front keeps taking beats until
// its command queue fills
// a tick holds each action until the next one is found; the last one goes
// out at the end of the walk with o_last_of_tick set
// a stalled receiver fills the four-entry result queue; the walk then holds
// on its current slot until room opens, no action is lost
// reset empties both queues, clears all slots, the time counter, the focus,
// the overflow flag and the three limits; no clearing pass is needed
module multi_level_idle_timeout_table_top #(
    parameter int ENTRIES = mlit_pkg::MLIT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command beats
    input  logic                           push,
    output logic                           full,
    input  logic [mlit_pkg::FUNC_W-1:0]    i_func,
    input  logic [mlit_pkg::ID_W-1:0]      i_item_id,
    // action beats
    output logic                           empty,
    input  logic                           pop,
    output logic [mlit_pkg::ID_W-1:0]      o_acted_id,
    output logic [mlit_pkg::LEVEL_W-1:0]   o_action_level,
    output logic                           o_last_of_tick,
    output logic                           o_table_overflowed,
    // config writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mlit_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlit_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import mlit_pkg::*;

    t_limits r_limits;
    t_cmd    cmd;
    logic    cmd_valid, cmd_pop;
    t_result res, res_out;
    logic    res_push, res_full;

    // unchecked user rule: limits change only while the table is quiet; no stall
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LIMIT_L0: r_limits[0] <= i_cfg_data;
                CFG_LIMIT_L1: r_limits[1] <= i_cfg_data;
                CFG_LIMIT_L2: r_limits[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: decode and queue commands
    mlit_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_item_id   (i_item_id),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // back: slot walk over the table memory
    mlit_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .i_limits    (r_limits),
        .i_out_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // result queue toward the receiver
    mlit_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_data  (res_out)
    );

    assign o_acted_id         = res_out.id;
    assign o_action_level     = res_out.level;
    assign o_last_of_tick     = res_out.last;
    assign o_table_overflowed = res_out.overflowed;

endmodule

### tb/sv/idle_action_checker.sv
`timescale 1ns / 1ps

// watches the command, config and action channels, keeps its own copy of the
// timeout table and compares every popped action with the oldest prediction
module idle_action_checker #(
    parameter int ENTRIES = mlit_pkg::MLIT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [mlit_pkg::FUNC_W-1:0]    i_func,
    input  logic [mlit_pkg::ID_W-1:0]      i_item_id,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [mlit_pkg::ID_W-1:0]      o_acted_id,
    input  logic [mlit_pkg::LEVEL_W-1:0]   o_action_level,
    input  logic                           o_last_of_tick,
    input  logic                           o_table_overflowed,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [mlit_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlit_pkg::LIMIT_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending_actions,
    output int                             o_actions_checked
);
    import mlit_pkg::*;

    localparam int MAX_PRINTED = 40;

    // shadow table
    bit                    tbl_valid [ENTRIES];
    logic [ID_W-1:0]       tbl_id    [ENTRIES];
    logic [TIME_W-1:0]     tbl_seen  [ENTRIES];
    logic [NUM_LEVELS-1:0] tbl_done  [ENTRIES];
    logic [LIMIT_W-1:0]    idle_limit [NUM_LEVELS];
    logic [ID_W-1:0]       focus_id;
    logic [TIME_W-1:0]     tick_now;
    bit                    overflowed;

    t_result expected_actions [$];
    int      mismatches = 0;
    int      checked    = 0;

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    task automatic clear_table();
        for (int s = 0; s < ENTRIES; s++) begin
            tbl_valid[s] = 1'b0;
        end
        for (int l = 0; l < NUM_LEVELS; l++) begin
            idle_limit[l] = '0;
        end
        focus_id   = '0;
        tick_now   = '0;
        overflowed = 1'b0;
    endtask

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int s = 0; s < ENTRIES; s++) begin
            if (tbl_valid[s] && tbl_id[s] == id)
                return s;
        end
        return -1;
    endfunction

    task automatic touch_slot(input int s);
        tbl_seen[s] = tick_now;
        tbl_done[s] = '0;
    endtask

    task automatic insert_id(input logic [ID_W-1:0] id);
        bit placed;
        placed = 1'b0;
        if (id == '0 || find_slot(id) >= 0)
            return;
        for (int s = 0; s < ENTRIES; s++) begin
            if (!placed && !tbl_valid[s]) begin
                tbl_valid[s] = 1'b1;
                tbl_id[s]    = id;
                touch_slot(s);
                placed       = 1'b1;
            end
        end
        if (!placed)
            overflowed = 1'b1;
    endtask

    // one tick: advance time, then walk the slots in order
    task automatic scan_for_actions();
        t_result    found [ENTRIES];
        int         n;
        bit         decided;
        logic [TIME_W:0] due;
        n = 0;
        if (tick_now != TIME_MAX)
            tick_now = tick_now + 1'b1;
        for (int s = 0; s < ENTRIES; s++) begin
            if (tbl_valid[s]) begin
                if (tbl_id[s] == focus_id) begin
                    tbl_seen[s] = tick_now;
                end else begin
                    decided = 1'b0;
                    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                        due = {1'b0, tbl_seen[s]} + {{(TIME_W+1-LIMIT_W){1'b0}}, idle_limit[l]};
                        if (!decided && idle_limit[l] != '0 && due <= {1'b0, tick_now}) begin
                            // highest elapsed level is the only candidate
                            decided = 1'b1;
                            if (!tbl_done[s][l]) begin
                                tbl_done[s][l]      = 1'b1;
                                found[n].id         = tbl_id[s];
                                found[n].level      = LEVEL_W'(l);
                                found[n].last       = 1'b0;
                                found[n].overflowed = overflowed;
                                n++;
                            end
                        end
                    end
                end
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) begin
            expected_actions.push_back(found[k]);
        end
    endtask

    task automatic predict_command(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id);
        int s;
        case (f)
            FUNC_ADD, FUNC_CONFIGURE: begin
                insert_id(id);
            end
            FUNC_DESTROY: begin
                s = find_slot(id);
                if (s >= 0)
                    tbl_valid[s] = 1'b0;
            end
            FUNC_FOCUS: begin
                insert_id(id);
                s = find_slot(focus_id);
                if (s >= 0)
                    touch_slot(s);
                s = find_slot(id);
                if (s >= 0)
                    touch_slot(s);
                focus_id = id;
            end
            FUNC_TICK: begin
                scan_for_actions();
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_action();
        t_result want;
        if (expected_actions.size() == 0) begin
            report_mismatch("action with nothing pending, id", o_acted_id, '0);
            return;
        end
        want = expected_actions.pop_front();
        checked++;
        if (o_acted_id !== want.id)
            report_mismatch("acted_id", o_acted_id, want.id);
        if (o_action_level !== want.level)
            report_mismatch("action_level", ID_W'(o_action_level), ID_W'(want.level));
        if (o_last_of_tick !== want.last)
            report_mismatch("last_of_tick", ID_W'(o_last_of_tick), ID_W'(want.last));
        if (o_table_overflowed !== want.overflowed)
            report_mismatch("table_overflowed", ID_W'(o_table_overflowed),
                            ID_W'(want.overflowed));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            expected_actions.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < NUM_LEVELS)
                idle_limit[i_cfg_index] = i_cfg_data;
            if (push && !full)
                predict_command(i_func, i_item_id);
            if (pop && !empty)
                check_action();
        end
        o_pending_actions <= expected_actions.size();
        o_fail_count      <= mismatches;
        o_actions_checked <= checked;
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mlit_pkg::*;

    localparam int ENTRIES      = MLIT_ENTRIES;
    // two queued commands plus the one in the walk, each a full slot walk, plus margin
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 3) + 16;
    localparam int POOL_SIZE    = 8;
    // index past the three limits, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // command side
    logic              push      = 1'b0;
    logic              full;
    logic [FUNC_W-1:0] i_func    = FUNC_ADD;
    logic [ID_W-1:0]   i_item_id = '0;

    // action side
    logic               empty;
    logic               pop = 1'b0;
    logic [ID_W-1:0]    o_acted_id;
    logic [LEVEL_W-1:0] o_action_level;
    logic               o_last_of_tick;
    logic               o_table_overflowed;

    // limit writes
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LIMIT_L0;
    logic [LIMIT_W-1:0]   i_cfg_data  = '0;

    // checker outputs
    int fail_count;
    int pending_actions;
    int actions_checked;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // stimulus bookkeeping
    int beats_sent   = 0;
    int limit_writes = 0;
    int settings_run = 0;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    always #6 i_clk = ~i_clk;

    multi_level_idle_timeout_table_top #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_func             (i_func),
        .i_item_id          (i_item_id),
        .empty              (empty),
        .pop                (pop),
        .o_acted_id         (o_acted_id),
        .o_action_level     (o_action_level),
        .o_last_of_tick     (o_last_of_tick),
        .o_table_overflowed (o_table_overflowed),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    idle_action_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_func             (i_func),
        .i_item_id          (i_item_id),
        .empty              (empty),
        .pop                (pop),
        .o_acted_id         (o_acted_id),
        .o_action_level     (o_action_level),
        .o_last_of_tick     (o_last_of_tick),
        .o_table_overflowed (o_table_overflowed),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending_actions  (pending_actions),
        .o_actions_checked  (actions_checked)
    );

    // receiver: pop dropped at random, one decision per cycle
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one command beat; push stays high after acceptance so back-to-back
    // beats never lower and raise it in the same step
    task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_func    <= f;
        i_item_id <= id;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    // sender holds off until every predicted action has been popped, then
    // lets the back end finish any command that causes no action
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_actions != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_writes++;
    endtask

    // only called with the block idle
    task automatic write_limits(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                                input logic [LIMIT_W-1:0] l2);
        write_reg(CFG_UNUSED, LIMIT_W'($urandom));
        write_reg(CFG_LIMIT_L0, l0);
        write_reg(CFG_LIMIT_L1, l1);
        write_reg(CFG_LIMIT_L2, l2);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_run++;
    endtask

    // mostly ids from a small pool so lookups hit, sometimes zero or fresh
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return id_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 83)
            return '0;
        else
            return ID_W'($urandom);
    endfunction

    // mixed traffic; ignored codes are sent too but not counted
    task automatic run_random(input int n_items);
        int done;
        int r;
        bit paused;
        done   = 0;
        paused = 1'b0;
        while (done < n_items) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_beat(FUNC_TICK, ID_W'($urandom));
            end else if (r < 58) begin
                send_beat(FUNC_ADD, pick_id());
            end else if (r < 66) begin
                send_beat(FUNC_CONFIGURE, pick_id());
            end else if (r < 78) begin
                send_beat(FUNC_DESTROY, pick_id());
            end else if (r < 92) begin
                send_beat(FUNC_FOCUS, pick_id());
            end else begin
                // unused function codes
                send_beat(FUNC_TICK + FUNC_W'($urandom_range(1, 3)), ID_W'($urandom));
                done--;
            end
            done++;
            // drain once mid-phase with the pipeline full of work
            if (!paused && done >= n_items / 2) begin
                paused = 1'b1;
                settle();
            end
        end
    endtask

    // push the table past its capacity so the overflow flag sets
    task automatic fill_table();
        for (int k = 0; k < ENTRIES + 4; k++) begin
            send_beat(FUNC_ADD, ID_W'($urandom) | ID_W'(1));
            if (k % 8 == 7)
                send_beat(FUNC_TICK, '0);
        end
        for (int k = 0; k < 4; k++) begin
            send_beat(FUNC_TICK, '1);
        end
        // free a few slots again
        for (int k = 0; k < 4; k++) begin
            send_beat(FUNC_DESTROY, id_pool[k]);
        end
    endtask

    initial begin
        id_pool[0] = 32'h0000_0001;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'h7FFF_FFFF;
        for (int k = 4; k < POOL_SIZE; k++) begin
            id_pool[k] = ID_W'($urandom) | ID_W'(1);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: sender rarely idles, receiver often
        send_idle_pct = 17;
        recv_idle_pct <= 64;
        write_limits(16'd2, 16'd4, 16'd6);

        // directed: empty table, zero ids, duplicates, unknown destroy
        send_beat(FUNC_TICK, '1);
        send_beat(FUNC_ADD, '0);
        send_beat(FUNC_CONFIGURE, '0);
        send_beat(FUNC_ADD, 32'h0000_0001);
        send_beat(FUNC_CONFIGURE, 32'hFFFF_FFFF);
        send_beat(FUNC_ADD, 32'h0000_0001);
        send_beat(FUNC_DESTROY, '0);
        send_beat(FUNC_DESTROY, 32'h1234_5678);
        // levels 0 and 1 come due for both ids
        repeat (4) send_beat(FUNC_TICK, '0);
        // focus refreshes one id, the other reaches level 2, then stays blocked
        send_beat(FUNC_FOCUS, 32'hFFFF_FFFF);
        repeat (3) send_beat(FUNC_TICK, 32'h5555_AAAA);
        // focus on zero still refreshes the old focus
        send_beat(FUNC_FOCUS, '0);
        send_beat(FUNC_TICK + FUNC_W'(1), 32'hAAAA_5555);
        send_beat(FUNC_TICK + FUNC_W'(3), '1);
        send_beat(FUNC_DESTROY, 32'hFFFF_FFFF);
        // focus inserts, then the focused id is destroyed and re-added
        send_beat(FUNC_FOCUS, 32'h8000_0000);
        send_beat(FUNC_DESTROY, 32'h8000_0000);
        send_beat(FUNC_CONFIGURE, 32'h8000_0000);
        send_beat(FUNC_TICK, '0);
        run_random(25);
        settle();

        // phase 2: roles swapped, table driven into overflow
        send_idle_pct = 64;
        recv_idle_pct <= 17;
        write_limits(16'd1, 16'd0, 16'hFFFF);
        fill_table();
        run_random(20);
        settle();

        // phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_limits(16'hFFFF, 16'd2, 16'd1);
        run_random(20);
        settle();

        // phase 4: level 0 disabled, equal upper limits
        write_limits(16'd0, 16'd5, 16'd5);
        run_random(15);
        settle();

        $display("run covered %0d command beats and %0d limit writes over %0d limit settings",
                 beats_sent, limit_writes, settings_run);
        $display("%0d idle actions compared, %0d mismatches", actions_checked, fail_count);
        if (fail_count == 0) begin
            $display("[multi_level_idle_timeout_table_top] OK");
        end else begin
            $display("[multi_level_idle_timeout_table_top] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[multi_level_idle_timeout_table_top] ERROR");
        $finish;
    end

endmodule
